// ===== rtl/task_priority_queue_manager_top_defines.svh =====
// ----------------------------------------------------------------------------
// task priority queue manager assertion macros
// shared property wrappers for the port checker
// ----------------------------------------------------------------------------
`ifndef TASK_PRIORITY_QUEUE_MANAGER_TOP_DEFINES_SVH
`define TASK_PRIORITY_QUEUE_MANAGER_TOP_DEFINES_SVH

// property checked outside reset
`define TPQ_CHECK(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// property checked on every edge, reset included
`define TPQ_CHECK_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ===== rtl/tpq_pkg.sv =====
// ----------------------------------------------------------------------------
// tpq_pkg
// shared constants, codes and types of the task priority queue manager
// ----------------------------------------------------------------------------
`default_nettype none

package tpq_pkg;

   localparam int TASK_SLOTS_DEF = 256;
   localparam int HEAP_DEPTH_DEF = 1024;

   localparam int FUNC_W = 2;
   localparam int USER_W = 16;
   localparam int TID_IN_W = 8;
   localparam int PRIO_W = 31;
   localparam int STATUS_W = 2;
   localparam int KEY_W = PRIO_W + TID_IN_W;
   localparam int REC_W = USER_W + PRIO_W;

   // operation codes
   localparam logic [FUNC_W-1:0] FUNC_ADD = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_EDIT = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_REMOVE = 2'd2;
   localparam logic [FUNC_W-1:0] FUNC_EXEC = 2'd3;

   // result status codes
   localparam logic [STATUS_W-1:0] STAT_DONE = 2'd0;
   localparam logic [STATUS_W-1:0] STAT_IGNORED = 2'd1;
   localparam logic [STATUS_W-1:0] STAT_FULL = 2'd2;
   localparam logic [STATUS_W-1:0] STAT_NO_LIVE = 2'd3;

   // command broadcast to every cell of the sorted chain
   typedef struct packed {
      logic ins;
      logic pop;
      logic [KEY_W-1:0] key;
   } cell_ctl_type;

endpackage

`default_nettype wire

// ===== rtl/tpq_cell.sv =====
// ----------------------------------------------------------------------------
// tpq_cell
// one slot of the sorted entry chain; keys descend from cell zero onward
// ----------------------------------------------------------------------------
`default_nettype none

module tpq_cell
   import tpq_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire cell_ctl_type     ctl,
   input  wire logic [KEY_W-1:0] left_key,
   input  wire logic             left_valid,
   input  wire logic             left_gt,
   input  wire logic [KEY_W-1:0] right_key,
   input  wire logic             right_valid,
   output logic      [KEY_W-1:0] key,
   output logic                  valid,
   output logic                  gt
);

   logic [KEY_W-1:0] key_ff, key_in;
   logic             valid_ff, valid_in;

   // new key belongs at or before this slot
   assign gt = !valid_ff || (key_ff < ctl.key);

   // insert shifts right from the insertion point, pop shifts left
   always_comb begin
      key_in = key_ff;
      valid_in = valid_ff;
      if (ctl.ins && gt) begin
         key_in = left_gt ? left_key : ctl.key;
         valid_in = left_gt ? left_valid : 1'b1;
      end else if (ctl.pop) begin
         key_in = right_key;
         valid_in = right_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff <= key_in;
   end

   assign key = key_ff;
   assign valid = valid_ff;

endmodule

`default_nettype wire

// ===== rtl/task_priority_queue_manager_top.sv =====
// ----------------------------------------------------------------------------
// task_priority_queue_manager_top
// task scheduler: sorted cell chain as max queue with lazy deletion
// ----------------------------------------------------------------------------
//  channel | direction | ports
//  req     | in        | req_valid, req_stall, req_func, req_user_id, req_task_id,
//          |           | req_priority_req
//  rsp     | out       | rsp_valid, rsp_stall, rsp_status, rsp_found, rsp_top_user
//
//  add, edit and remove step through accept, record memory read and result
//  execute top steps through accept and read, then per popped entry a chain
//  shift and a record memory read of the popped task, until a live task is found or the queue runs empty
//  synchronous reset empties the chain and clears all live bits
//  a result waiting on rsp_stall holds the sequencer in its result step
// ----------------------------------------------------------------------------
`default_nettype none

module task_priority_queue_manager_top
   import tpq_pkg::*;
#(
   parameter int TASK_SLOTS = TASK_SLOTS_DEF,
   parameter int HEAP_DEPTH = HEAP_DEPTH_DEF
)
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_stall,
   input  wire logic [FUNC_W-1:0]   req_func,
   input  wire logic [USER_W-1:0]   req_user_id,
   input  wire logic [TID_IN_W-1:0] req_task_id,
   input  wire logic [PRIO_W-1:0]   req_priority_req,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output logic [STATUS_W-1:0]      rsp_status,
   output logic                     rsp_found,
   output logic [USER_W-1:0]        rsp_top_user
);

   localparam int TID_W = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
   localparam int CNT_W = $clog2(HEAP_DEPTH + 1);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_READ = 3'd1;
   localparam logic [2:0] S_POP = 3'd2;
   localparam logic [2:0] S_CHK = 3'd3;
   localparam logic [2:0] S_DONE = 3'd4;

   logic [2:0]          state_ff, state_in;
   logic [FUNC_W-1:0]   func_ff;
   logic [USER_W-1:0]   user_ff;
   logic [TID_IN_W-1:0] tid_ff;
   logic [PRIO_W-1:0]   prio_ff;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [TID_IN_W-1:0] eid_ff, eid_in;
   logic [PRIO_W-1:0]   eprio_ff, eprio_in;
   logic [STATUS_W-1:0] res_status_ff, res_status_in;
   logic                res_found_ff, res_found_in;
   logic [USER_W-1:0]   res_user_ff, res_user_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] rsp_status_ff;
   logic                rsp_found_ff;
   logic [USER_W-1:0]   rsp_user_ff;
   logic [TASK_SLOTS-1:0] live_ff;
   logic [REC_W-1:0]    rec_mem [TASK_SLOTS];
   logic [REC_W-1:0]    rec_rd_ff;

   logic             accept;
   logic             full;
   logic             push, pop;
   logic             rec_we;
   logic [REC_W-1:0] rec_wdata;
   logic [TID_W-1:0] rd_addr;
   logic [TID_W-1:0] tid_addr, eid_addr;
   logic             tid_in_range, eid_in_range;
   logic             live_set, live_clr;
   logic [TID_W-1:0] live_idx;
   logic             rsp_load;
   logic [PRIO_W-1:0] rec_prio;
   logic [USER_W-1:0] rec_user;
   cell_ctl_type     ctl;

   logic [KEY_W-1:0] key_w   [HEAP_DEPTH];
   logic             valid_w [HEAP_DEPTH];
   logic             gt_w    [HEAP_DEPTH];

   assign accept = req_valid && !req_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign full = (count_ff == CNT_W'(HEAP_DEPTH));
   assign tid_addr = TID_W'(tid_ff);
   assign eid_addr = TID_W'(eid_ff);
   assign tid_in_range = (32'(tid_ff) < 32'(TASK_SLOTS));
   assign eid_in_range = (32'(eid_ff) < 32'(TASK_SLOTS));
   assign rec_prio = rec_rd_ff[PRIO_W-1:0];
   assign rec_user = rec_rd_ff[REC_W-1:PRIO_W];
   assign rsp_load = !rsp_valid_ff || !rsp_stall;

   // sequencer
   always_comb begin
      state_in = state_ff;
      push = 1'b0;
      pop = 1'b0;
      rec_we = 1'b0;
      rec_wdata = {user_ff, prio_ff};
      rd_addr = TID_W'(req_task_id);
      live_set = 1'b0;
      live_clr = 1'b0;
      live_idx = tid_addr;
      eid_in = eid_ff;
      eprio_in = eprio_ff;
      res_status_in = res_status_ff;
      res_found_in = res_found_ff;
      res_user_in = res_user_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = S_READ;
            end
         end
         S_READ: begin
            res_status_in = STAT_IGNORED;
            res_found_in = 1'b0;
            res_user_in = '0;
            state_in = S_DONE;
            case (func_ff)
               FUNC_ADD: begin
                  if (tid_in_range) begin
                     if (full) begin
                        res_status_in = STAT_FULL;
                     end else begin
                        push = 1'b1;
                        rec_we = 1'b1;
                        live_set = 1'b1;
                        res_status_in = STAT_DONE;
                     end
                  end
               end
               FUNC_EDIT: begin
                  if (tid_in_range && live_ff[tid_addr] && rec_prio != prio_ff) begin
                     if (full) begin
                        res_status_in = STAT_FULL;
                     end else begin
                        push = 1'b1;
                        rec_we = 1'b1;
                        rec_wdata = {rec_user, prio_ff};
                        res_status_in = STAT_DONE;
                     end
                  end
               end
               FUNC_REMOVE: begin
                  if (tid_in_range && live_ff[tid_addr]) begin
                     live_clr = 1'b1;
                     res_status_in = STAT_DONE;
                  end
               end
               default: begin
                  state_in = S_POP;
               end
            endcase
         end
         S_POP: begin
            rd_addr = TID_W'(key_w[0][TID_IN_W-1:0]);
            if (count_ff == '0) begin
               res_status_in = STAT_NO_LIVE;
               state_in = S_DONE;
            end else begin
               pop = 1'b1;
               eid_in = key_w[0][TID_IN_W-1:0];
               eprio_in = key_w[0][KEY_W-1:TID_IN_W];
               state_in = S_CHK;
            end
         end
         S_CHK: begin
            live_idx = eid_addr;
            if (eid_in_range && live_ff[eid_addr] && rec_prio == eprio_ff) begin
               live_clr = 1'b1;
               res_status_in = STAT_DONE;
               res_found_in = 1'b1;
               res_user_in = rec_user;
               state_in = S_DONE;
            end else begin
               state_in = S_POP;
            end
         end
         S_DONE: begin
            if (rsp_load) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // entry count
   always_comb begin
      count_in = count_ff;
      if (push) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   // result register toward the consumer
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (state_ff == S_DONE && rsp_load) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         rsp_valid_ff <= 1'b0;
         live_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         if (live_set) begin
            live_ff[live_idx] <= 1'b1;
         end
         if (live_clr) begin
            live_ff[live_idx] <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         func_ff <= req_func;
         user_ff <= req_user_id;
         tid_ff <= req_task_id;
         prio_ff <= req_priority_req;
      end
      eid_ff <= eid_in;
      eprio_ff <= eprio_in;
      res_status_ff <= res_status_in;
      res_found_ff <= res_found_in;
      res_user_ff <= res_user_in;
      if (state_ff == S_DONE && rsp_load) begin
         rsp_status_ff <= res_status_ff;
         rsp_found_ff <= res_found_ff;
         rsp_user_ff <= res_user_ff;
      end
   end

   // task record memory
   always_ff @(posedge clock) begin
      if (rec_we) begin
         rec_mem[tid_addr] <= rec_wdata;
      end
      rec_rd_ff <= rec_mem[rd_addr];
   end

   // sorted chain of cells
   assign ctl.ins = push;
   assign ctl.pop = pop;
   assign ctl.key = {prio_ff, tid_ff};

   for (genvar i = 0; i < HEAP_DEPTH; i++) begin : g_cell
      logic [KEY_W-1:0] lk, rk;
      logic             lv, lg, rv;
      if (i == 0) begin : g_first
         assign lk = '0;
         assign lv = 1'b0;
         assign lg = 1'b0;
      end else begin : g_mid
         assign lk = key_w[i-1];
         assign lv = valid_w[i-1];
         assign lg = gt_w[i-1];
      end
      if (i == HEAP_DEPTH - 1) begin : g_last
         assign rk = '0;
         assign rv = 1'b0;
      end else begin : g_inner
         assign rk = key_w[i+1];
         assign rv = valid_w[i+1];
      end
      tpq_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctl         (ctl),
         .left_key    (lk),
         .left_valid  (lv),
         .left_gt     (lg),
         .right_key   (rk),
         .right_valid (rv),
         .key         (key_w[i]),
         .valid       (valid_w[i]),
         .gt          (gt_w[i])
      );
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_found = rsp_found_ff;
   assign rsp_top_user = rsp_user_ff;

endmodule

`default_nettype wire

// ===== rtl/tpq_checker.sv =====
// ----------------------------------------------------------------------------
// tpq_checker
// port level checks of the task priority queue manager
// ----------------------------------------------------------------------------
`default_nettype none

`include "task_priority_queue_manager_top_defines.svh"

module tpq_checker
   import tpq_pkg::*;
(
   input wire logic                clock,
   input wire logic                reset,
   input wire logic                req_valid,
   input wire logic                req_stall,
   input wire logic [FUNC_W-1:0]   req_func,
   input wire logic [USER_W-1:0]   req_user_id,
   input wire logic [TID_IN_W-1:0] req_task_id,
   input wire logic [PRIO_W-1:0]   req_priority_req,
   input wire logic                rsp_valid,
   input wire logic                rsp_stall,
   input wire logic [STATUS_W-1:0] rsp_status,
   input wire logic                rsp_found,
   input wire logic [USER_W-1:0]   rsp_top_user
);

   // a stalled item keeps its payload
   `TPQ_CHECK(a_rsp_hold, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_status) && $stable(rsp_found) && $stable(rsp_top_user), "rsp item changed under stall")

   // a found task is always a completed execute
   `TPQ_CHECK(a_found_done, rsp_valid && rsp_found |-> rsp_status == STAT_DONE, "found without done status")

   // no task returned means user is zero
   `TPQ_CHECK(a_user_zero, rsp_valid && !rsp_found |-> rsp_top_user == '0, "top user set without found")

   // nothing leaves right after reset
   `TPQ_CHECK_ALWAYS(a_reset_quiet, reset |=> !rsp_valid, "rsp item right after reset")

endmodule

bind task_priority_queue_manager_top tpq_checker u_tpq_checker (.*);

`default_nettype wire

// ===== test/task_priority_queue_manager_top_tb.sv =====
// ----------------------------------------------------------------------------
// task_priority_queue_manager_top_tb
// A directed table of operations runs first and covers the edge cases: an
// empty queue, ties on priority, stale and duplicate entries, a remove
// followed by a fresh add, and an add over a live task. Random operations
// follow, with one pause until every result is back and a final stretch
// without idling. A scoreboard predicts or takes from the table every
// result and checks each one against the DUT.
// ----------------------------------------------------------------------------
`default_nettype none

module task_priority_queue_manager_top_tb;
   import tpq_pkg::*;

   localparam int SLOTS = TASK_SLOTS_DEF;
   localparam int DEPTH = HEAP_DEPTH_DEF;

   typedef struct {
      logic [STATUS_W-1:0] status;
      logic                found;
      logic [USER_W-1:0]   top_user;
   } answer_t;

   typedef struct {
      logic [FUNC_W-1:0]   func;
      logic [USER_W-1:0]   user;
      logic [TID_IN_W-1:0] tid;
      logic [PRIO_W-1:0]   prio;
      bit                  typed;
      answer_t             ans;
   } row_t;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic [FUNC_W-1:0]   req_func = FUNC_ADD;
   logic [USER_W-1:0]   req_user_id = '0;
   logic [TID_IN_W-1:0] req_task_id = '0;
   logic [PRIO_W-1:0]   req_priority_req = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic [STATUS_W-1:0] rsp_status;
   logic                rsp_found;
   logic [USER_W-1:0]   rsp_top_user;

   // scheduler shadow state
   bit                task_live [SLOTS];
   logic [USER_W-1:0] task_user [SLOTS];
   bit   [PRIO_W-1:0] task_prio [SLOTS];
   logic [KEY_W-1:0]  heap_keys [$];

   answer_t pending_answers [$];
   int      mismatches = 0;
   bit      quiet = 1'b0;
   int      stall_left = 0;

   task_priority_queue_manager_top u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_func(req_func),
      .req_user_id(req_user_id), .req_task_id(req_task_id),
      .req_priority_req(req_priority_req),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_status(rsp_status),
      .rsp_found(rsp_found), .rsp_top_user(rsp_top_user)
   );

   always #5 clock = ~clock;

   // push one key into the shadow heap, 0 when full
   function automatic bit heap_insert(logic [PRIO_W-1:0] p, logic [TID_IN_W-1:0] t);
      if (heap_keys.size() >= DEPTH) return 1'b0;
      heap_keys.push_back({p, t});
      return 1'b1;
   endfunction

   // compute the scheduler answer and update the shadow state
   function automatic answer_t schedule(logic [FUNC_W-1:0] f, logic [USER_W-1:0] u,
                                        logic [TID_IN_W-1:0] t, logic [PRIO_W-1:0] p);
      answer_t a;
      int best;
      logic [KEY_W-1:0] k;
      a = '{STAT_IGNORED, 1'b0, '0};
      case (f)
         FUNC_ADD: begin
            if (heap_insert(p, t)) begin
               task_user[t] = u;
               task_prio[t] = p;
               task_live[t] = 1'b1;
               a.status = STAT_DONE;
            end else a.status = STAT_FULL;
         end
         FUNC_EDIT: begin
            if (task_live[t] && task_prio[t] != p) begin
               if (heap_insert(p, t)) begin
                  task_prio[t] = p;
                  a.status = STAT_DONE;
               end else a.status = STAT_FULL;
            end
         end
         FUNC_REMOVE: begin
            if (task_live[t]) begin
               task_live[t] = 1'b0;
               a.status = STAT_DONE;
            end
         end
         default: begin
            a.status = STAT_NO_LIVE;
            // pop largest keys until a live one turns up
            while (heap_keys.size() > 0) begin
               best = 0;
               foreach (heap_keys[i]) if (heap_keys[i] > heap_keys[best]) best = i;
               k = heap_keys[best];
               heap_keys.delete(best);
               if (task_live[k[7:0]] && task_prio[k[7:0]] == k[KEY_W-1:8]) begin
                  task_live[k[7:0]] = 1'b0;
                  a = '{STAT_DONE, 1'b1, task_user[k[7:0]]};
                  break;
               end
            end
         end
      endcase
      return a;
   endfunction

   // present one item, wait for acceptance, then maybe idle a while
   task automatic send(row_t r);
      answer_t a;
      int gap;
      req_func <= r.func;
      req_user_id <= r.user;
      req_task_id <= r.tid;
      req_priority_req <= r.prio;
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall);
      a = schedule(r.func, r.user, r.tid, r.prio);
      pending_answers.push_back(r.typed ? r.ans : a);
      if (!quiet && $urandom_range(0, 7) == 0) begin
         gap = $urandom_range(1, 10);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic send_op(logic [FUNC_W-1:0] f, logic [USER_W-1:0] u,
                          logic [TID_IN_W-1:0] t, logic [PRIO_W-1:0] p);
      send('{f, u, t, p, 1'b0, '{STAT_DONE, 1'b0, '0}});
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (pending_answers.size() != 0) @(posedge clock);
   endtask

   // receiver stall bursts
   always @(posedge clock) begin
      if (quiet || reset) begin
         rsp_stall <= 1'b0;
         stall_left <= 0;
      end else if (stall_left > 0) begin
         rsp_stall <= 1'b1;
         stall_left <= stall_left - 1;
      end else if ($urandom_range(0, 9) == 0) begin
         rsp_stall <= 1'b1;
         stall_left <= $urandom_range(0, 9);
      end else rsp_stall <= 1'b0;
   end

   // result checker
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_answers.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result status %0d", rsp_status);
         end else begin
            answer_t e;
            e = pending_answers.pop_front();
            if (rsp_status !== e.status || rsp_found !== e.found
                || rsp_top_user !== e.top_user) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected %0d/%0d/%h got %0d/%0d/%h",
                           e.status, e.found, e.top_user,
                           rsp_status, rsp_found, rsp_top_user);
            end
         end
      end
   end

   // watchdog
   initial begin
      #5000000;
      $display("task_priority_queue_manager_top_tb: done, errors");
      $finish;
   end

   initial begin
      row_t table_rows [$];
      int r;
      logic [FUNC_W-1:0] f;
      logic [TID_IN_W-1:0] t;
      logic [PRIO_W-1:0] p;

      // empty queue, ties, stale entries, re-add after remove, overwrite
      table_rows = '{
         '{FUNC_EXEC,   16'h0,    8'd0,   31'd0,          1, '{STAT_NO_LIVE, 0, 16'h0}},
         '{FUNC_REMOVE, 16'h0,    8'd0,   31'd0,          1, '{STAT_IGNORED, 0, 16'h0}},
         '{FUNC_EDIT,   16'h0,    8'd255, 31'd4,          1, '{STAT_IGNORED, 0, 16'h0}},
         '{FUNC_ADD,    16'hFFFF, 8'd255, 31'h7FFFFFFF,   1, '{STAT_DONE, 0, 16'h0}},
         '{FUNC_ADD,    16'h0,    8'd0,   31'd0,          1, '{STAT_DONE, 0, 16'h0}},
         '{FUNC_ADD,    16'h1234, 8'd7,   31'h7FFFFFFF,   1, '{STAT_DONE, 0, 16'h0}},
         '{FUNC_EDIT,   16'h0,    8'd7,   31'h7FFFFFFF,   1, '{STAT_IGNORED, 0, 16'h0}},
         '{FUNC_EDIT,   16'h0,    8'd0,   31'd5,          1, '{STAT_DONE, 0, 16'h0}},
         '{FUNC_EXEC,   16'h0,    8'd0,   31'd0,          1, '{STAT_DONE, 1, 16'hFFFF}},
         '{FUNC_EXEC,   16'h0,    8'd0,   31'd0,          1, '{STAT_DONE, 1, 16'h1234}},
         '{FUNC_EXEC,   16'h0,    8'd0,   31'd0,          1, '{STAT_DONE, 1, 16'h0}},
         '{FUNC_EXEC,   16'h0,    8'd0,   31'd0,          1, '{STAT_NO_LIVE, 0, 16'h0}},
         '{FUNC_ADD,    16'hAAAA, 8'd3,   31'd100,        0, '{STAT_DONE, 0, 16'h0}},
         '{FUNC_REMOVE, 16'h0,    8'd3,   31'd0,          1, '{STAT_DONE, 0, 16'h0}},
         '{FUNC_ADD,    16'h5555, 8'd3,   31'd100,        0, '{STAT_DONE, 0, 16'h0}},
         '{FUNC_EXEC,   16'h0,    8'd0,   31'd0,          1, '{STAT_DONE, 1, 16'h5555}},
         '{FUNC_EXEC,   16'h0,    8'd0,   31'd0,          1, '{STAT_NO_LIVE, 0, 16'h0}},
         '{FUNC_ADD,    16'h0001, 8'd9,   31'd50,         0, '{STAT_DONE, 0, 16'h0}},
         '{FUNC_ADD,    16'h0002, 8'd9,   31'd60,         0, '{STAT_DONE, 0, 16'h0}},
         '{FUNC_EXEC,   16'h0,    8'd0,   31'd0,          0, '{STAT_DONE, 0, 16'h0}},
         '{FUNC_EXEC,   16'h0,    8'd0,   31'd0,          1, '{STAT_NO_LIVE, 0, 16'h0}}
      };

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (table_rows[i]) send(table_rows[i]);

      // random operations on a small pool of task ids
      for (int n = 0; n < 530; n++) begin
         // wait for every answer once midway
         if (n == 265) drain();
         if (n == 430) quiet = 1'b1;
         r = $urandom_range(0, 99);
         f = r < 40 ? FUNC_ADD : r < 60 ? FUNC_EDIT : r < 72 ? FUNC_REMOVE : FUNC_EXEC;
         t = $urandom_range(0, 9) == 0 ? $urandom_range(0, 255) : $urandom_range(0, 15);
         case ($urandom_range(0, 3))
            0: p = $urandom_range(0, 7);
            1: p = $urandom;
            2: p = $urandom_range(0, 1) ? 31'h7FFFFFFF : 31'd0;
            default: p = task_prio[t];
         endcase
         send_op(f, $urandom, t, p);
      end

      drain();
      repeat (20) @(posedge clock);
      if (mismatches == 0 && pending_answers.size() == 0)
         $display("task_priority_queue_manager_top_tb: done, clean");
      else
         $display("task_priority_queue_manager_top_tb: done, errors");
      $finish;
   end

endmodule

`default_nettype wire
